// ===== rtl/wsfb_pkg.sv =====
// Shared types and constants of the WebSocket frame builder.
package wsfb_pkg;

    // Input and output field widths.
    localparam int OPCODE_W   = 4;
    localparam int LEN_W      = 63;
    localparam int KEY_W      = 32;
    localparam int BYTE_W     = 8;

    // Input tdata layout, lowest bit first.
    localparam int S_OPCODE_LSB  = 0;
    localparam int S_MASK_LSB    = S_OPCODE_LSB + OPCODE_W;
    localparam int S_LEN_LSB     = S_MASK_LSB + 1;
    localparam int S_KEY_LSB     = S_LEN_LSB + LEN_W;
    localparam int S_PAYLOAD_LSB = S_KEY_LSB + KEY_W;
    localparam int S_FIELDS_W    = S_PAYLOAD_LSB + BYTE_W;
    localparam int S_TDATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // Command codes carried on s_tuser.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Header constants.
    localparam logic [BYTE_W-1:0] FIN_BIT     = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_BIT    = 8'h80;
    localparam logic [6:0]        LEN_CODE_16 = 7'd126;
    localparam logic [6:0]        LEN_CODE_64 = 7'd127;
    localparam logic [15:0]       LEN_MAX_16  = 16'hFFFF;

    // Length encoding of a header.
    localparam logic [1:0] LEN_SHORT = 2'd0;
    localparam logic [1:0] LEN_MED   = 2'd1;
    localparam logic [1:0] LEN_LONG  = 2'd2;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;

    // One classified item, ready for the back end.
    typedef struct packed {
        logic                is_header;
        logic [BYTE_W-1:0]   first_byte;
        logic [BYTE_W-1:0]   second_byte;
        logic [1:0]          len_mode;
        logic [LEN_W-1:0]    len;
        logic [KEY_W-1:0]    key;
        logic                masked;
        logic                len_zero;
        logic [BYTE_W-1:0]   data_byte;
        logic                frame_end;
        logic                error;
    } job_t;

endpackage

// ===== rtl/wsfb_front.sv =====
// Front end: accepts items, tracks frame state and classifies each item into a job.
module wsfb_front (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    input  logic                    in_cmd,
    input  logic [wsfb_pkg::S_TDATA_W-1:0] in_data,
    input  logic                    queue_full,
    output logic                    in_ready,
    output logic                    push,
    output wsfb_pkg::job_t          push_job
);

    logic [wsfb_pkg::LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [wsfb_pkg::KEY_W-1:0]    key_store_reg, key_store_next;
    logic [1:0]                    key_pos_reg, key_pos_next;

    logic [wsfb_pkg::OPCODE_W-1:0] opcode;
    logic                          masked;
    logic [wsfb_pkg::LEN_W-1:0]    len;
    logic [wsfb_pkg::KEY_W-1:0]    key;
    logic [wsfb_pkg::BYTE_W-1:0]   payload;
    logic                          len_short;
    logic                          len_med;
    logic [6:0]                    len_code;
    logic [wsfb_pkg::BYTE_W-1:0]   key_byte;

    assign opcode  = in_data[wsfb_pkg::S_OPCODE_LSB +: wsfb_pkg::OPCODE_W];
    assign masked  = in_data[wsfb_pkg::S_MASK_LSB];
    assign len     = in_data[wsfb_pkg::S_LEN_LSB +: wsfb_pkg::LEN_W];
    assign key     = in_data[wsfb_pkg::S_KEY_LSB +: wsfb_pkg::KEY_W];
    assign payload = in_data[wsfb_pkg::S_PAYLOAD_LSB +: wsfb_pkg::BYTE_W];

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    assign len_short = (len < wsfb_pkg::LEN_W'(126));
    assign len_med   = (len[wsfb_pkg::LEN_W-1:16] == '0);

    always_comb begin
        if (len_short) begin
            len_code = len[6:0];
        end else if (len_med) begin
            len_code = wsfb_pkg::LEN_CODE_16;
        end else begin
            len_code = wsfb_pkg::LEN_CODE_64;
        end
    end

    // Key byte for the current payload position; bits 31:24 go first.
    always_comb begin
        case (key_pos_reg)
            2'd0:    key_byte = key_store_reg[31:24];
            2'd1:    key_byte = key_store_reg[23:16];
            2'd2:    key_byte = key_store_reg[15:8];
            default: key_byte = key_store_reg[7:0];
        endcase
    end

    always_comb begin
        push_job        = '0;
        bytes_left_next = bytes_left_reg;
        key_store_next  = key_store_reg;
        key_pos_next    = key_pos_reg;

        if (in_cmd == wsfb_pkg::CMD_START) begin
            push_job.is_header   = 1'b1;
            push_job.first_byte  = wsfb_pkg::FIN_BIT | {4'd0, opcode};
            push_job.second_byte = (masked ? wsfb_pkg::MASK_BIT : 8'h00) | {1'b0, len_code};
            if (len_short) begin
                push_job.len_mode = wsfb_pkg::LEN_SHORT;
            end else if (len_med) begin
                push_job.len_mode = wsfb_pkg::LEN_MED;
            end else begin
                push_job.len_mode = wsfb_pkg::LEN_LONG;
            end
            push_job.len      = len;
            push_job.key      = key;
            push_job.masked   = masked;
            push_job.len_zero = (len == '0);

            // A start replaces whatever frame was open.
            bytes_left_next = len;
            key_store_next  = masked ? key : '0;
            key_pos_next    = 2'd0;
        end else if (bytes_left_reg == '0) begin
            // Payload byte with no open frame: one error result, state kept.
            push_job.error = 1'b1;
        end else begin
            // Key store is zero for unmasked frames, so the XOR is a no-op there.
            push_job.data_byte = payload ^ key_byte;
            push_job.frame_end = (bytes_left_reg == wsfb_pkg::LEN_W'(1));
            bytes_left_next    = bytes_left_reg - wsfb_pkg::LEN_W'(1);
            key_pos_next       = key_pos_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_left_reg <= '0;
            key_store_reg  <= '0;
            key_pos_reg    <= 2'd0;
        end else if (push) begin
            bytes_left_reg <= bytes_left_next;
            key_store_reg  <= key_store_next;
            key_pos_reg    <= key_pos_next;
        end
    end

endmodule

// ===== rtl/wsfb_fifo.sv =====
// Short job queue that decouples the front end from the byte sequencer.
module wsfb_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  wsfb_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           empty,
    output wsfb_pkg::job_t head_job
);

    wsfb_pkg::job_t                    store [wsfb_pkg::QUEUE_DEPTH];
    logic [wsfb_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [wsfb_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [wsfb_pkg::QUEUE_CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == wsfb_pkg::QUEUE_CNT_W'(wsfb_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = store[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + wsfb_pkg::QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - wsfb_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + wsfb_pkg::QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + wsfb_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/wsfb_back.sv =====
// Back end: expands header jobs into bytes and drives the registered output stage.
module wsfb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         queue_empty,
    input  wsfb_pkg::job_t               head_job,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [wsfb_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_last,
    output logic                         out_frame_end,
    output logic                         out_error
);

    localparam logic [1:0] PH_SECOND = 2'd0;
    localparam logic [1:0] PH_LEN    = 2'd1;
    localparam logic [1:0] PH_KEY    = 2'd2;

    logic                         busy_reg, busy_next;
    logic [1:0]                   phase_reg, phase_next;
    logic [2:0]                   cnt_reg, cnt_next;
    logic [63:0]                  len_sr_reg, len_sr_next;
    logic [wsfb_pkg::KEY_W-1:0]   key_sr_reg, key_sr_next;
    logic [wsfb_pkg::BYTE_W-1:0]  second_reg, second_next;
    logic [1:0]                   len_mode_reg, len_mode_next;
    logic                         masked_reg, masked_next;
    logic                         len_zero_reg, len_zero_next;

    logic                         out_valid_reg;
    logic [wsfb_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                         out_last_reg;
    logic                         out_fend_reg;
    logic                         out_err_reg;

    logic                         advance;
    logic                         emit_valid;
    logic [wsfb_pkg::BYTE_W-1:0]  emit_byte;
    logic                         emit_last;
    logic                         emit_fend;
    logic                         emit_err;

    assign advance = !out_valid_reg || out_ready;
    assign pop     = advance && !busy_reg && !queue_empty;

    always_comb begin
        busy_next     = busy_reg;
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        len_sr_next   = len_sr_reg;
        key_sr_next   = key_sr_reg;
        second_next   = second_reg;
        len_mode_next = len_mode_reg;
        masked_next   = masked_reg;
        len_zero_next = len_zero_reg;
        emit_valid    = 1'b0;
        emit_byte     = '0;
        emit_last     = 1'b0;
        emit_fend     = 1'b0;
        emit_err      = 1'b0;

        if (busy_reg) begin
            emit_valid = 1'b1;
            unique case (phase_reg)
                PH_SECOND: begin
                    emit_byte = second_reg;
                    if (len_mode_reg == wsfb_pkg::LEN_SHORT) begin
                        if (masked_reg) begin
                            phase_next = PH_KEY;
                            cnt_next   = 3'd3;
                        end else begin
                            emit_last = 1'b1;
                            busy_next = 1'b0;
                        end
                    end else begin
                        phase_next = PH_LEN;
                        cnt_next   = (len_mode_reg == wsfb_pkg::LEN_MED) ? 3'd1 : 3'd7;
                    end
                end
                PH_LEN: begin
                    emit_byte   = len_sr_reg[63:56];
                    len_sr_next = {len_sr_reg[55:0], 8'h00};
                    if (cnt_reg == 3'd0) begin
                        if (masked_reg) begin
                            phase_next = PH_KEY;
                            cnt_next   = 3'd3;
                        end else begin
                            emit_last = 1'b1;
                            busy_next = 1'b0;
                        end
                    end else begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                PH_KEY: begin
                    emit_byte   = key_sr_reg[31:24];
                    key_sr_next = {key_sr_reg[23:0], 8'h00};
                    if (cnt_reg == 3'd0) begin
                        emit_last = 1'b1;
                        busy_next = 1'b0;
                    end else begin
                        cnt_next = cnt_reg - 3'd1;
                    end
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
            emit_fend = emit_last && len_zero_reg;
        end else if (!queue_empty) begin
            emit_valid = 1'b1;
            if (head_job.is_header) begin
                // First header byte goes out as the job is taken.
                emit_byte     = head_job.first_byte;
                busy_next     = 1'b1;
                phase_next    = PH_SECOND;
                cnt_next      = 3'd0;
                second_next   = head_job.second_byte;
                len_mode_next = head_job.len_mode;
                masked_next   = head_job.masked;
                len_zero_next = head_job.len_zero;
                key_sr_next   = head_job.key;
                if (head_job.len_mode == wsfb_pkg::LEN_MED) begin
                    len_sr_next = {head_job.len[15:0], 48'd0};
                end else begin
                    len_sr_next = {1'b0, head_job.len};
                end
            end else begin
                emit_byte = head_job.data_byte;
                emit_last = 1'b1;
                emit_fend = head_job.frame_end;
                emit_err  = head_job.error;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            busy_reg      <= busy_next;
            out_valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            phase_reg    <= phase_next;
            cnt_reg      <= cnt_next;
            len_sr_reg   <= len_sr_next;
            key_sr_reg   <= key_sr_next;
            second_reg   <= second_next;
            len_mode_reg <= len_mode_next;
            masked_reg   <= masked_next;
            len_zero_reg <= len_zero_next;
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_fend_reg <= emit_fend;
            out_err_reg  <= emit_err;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign out_last      = out_last_reg;
    assign out_frame_end = out_fend_reg;
    assign out_error     = out_err_reg;

endmodule

// ===== rtl/websocket_frame_builder.sv =====
// Top level of the WebSocket frame builder: front end, job queue and byte sequencer.
//
// This block turns start and payload transactions into a WebSocket (RFC 6455) byte
// stream, one byte per output transaction. A start transaction (s_tuser = 0) emits
// the header: FIN plus opcode, the mask bit with the 7-bit length code, then a
// 16-bit or 64-bit big-endian extended length where needed, then the four key bytes
// (bits 31:24 first) when masking is on; that is 2 to 14 output bytes. Each payload
// transaction (s_tuser = 1) emits one byte, XORed with the rolling key byte when the
// frame is masked, with m_tuser[0] set on the last byte of the frame. A payload byte
// with no frame open yields one byte of zero with m_tuser[1] set. A new start
// abandons any open frame. m_tlast marks the last output byte of each input
// transaction. Payload streams at one byte per clock while m_tready is high and no
// header is being sequenced; a start transaction holds the byte sequencer while its
// header bytes go out in turn. The front end keeps accepting input while a header
// is being sequenced until the four-entry job queue is full, and input keeps flowing
// into that queue while a result waits on m_tready in the registered output stage.
module websocket_frame_builder (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, lowest bit up: opcode[3:0], mask_enable[4], payload_length[67:5],
    // mask_key[99:68], payload_byte[107:100], zero fill[111:108].
    input  logic [wsfb_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: command (0 = start frame, 1 = payload byte).
    input  logic                              s_tuser,
    // Output stream.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_byte[7:0].
    output logic [wsfb_pkg::BYTE_W-1:0]       m_tdata,
    output logic                              m_tlast,
    // m_tuser, lowest bit up: frame_end[0], error[1].
    output logic [1:0]                        m_tuser
);

    logic           push;
    wsfb_pkg::job_t push_job;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;
    wsfb_pkg::job_t head_job;
    logic           out_frame_end;
    logic           out_error;

    // The front end owns the frame state, so every transaction is fully resolved
    // (payload masked, frame end and error decided) before it enters the queue.
    wsfb_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_cmd     (s_tuser),
        .in_data    (s_tdata),
        .queue_full (queue_full),
        .in_ready   (s_tready),
        .push       (push),
        .push_job   (push_job)
    );

    wsfb_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head_job (head_job)
    );

    // The back end walks header jobs byte by byte and passes payload jobs through.
    wsfb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .queue_empty   (queue_empty),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_byte      (m_tdata),
        .out_last      (m_tlast),
        .out_frame_end (out_frame_end),
        .out_error     (out_error)
    );

    assign m_tuser = {out_error, out_frame_end};

endmodule
